### hdl/assert_macros.svh
// Assertion macros shared by the envelope detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SEDU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define SEDU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### hdl/sedu_pkg.sv
// Package with types, constants and codes of the streaming envelope detector.
`timescale 1ns / 1ps

package sedu_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int WINDOW_MAX_DEF  = 1024;
   localparam int ENV_BITS        = 25;
   localparam int COEF_BITS       = 16;
   localparam int WLEN_BITS       = 11;
   localparam int MODE_BITS       = 2;
   localparam int CSR_ADDR_BITS   = 2;
   localparam int PEAK_BITS       = 24;
   localparam int SUM_BITS        = 41;
   localparam int MEAN_BITS       = 57;
   localparam int MUL_BITS        = 32;
   localparam int MUL_DIGIT       = 4;

   // Operating modes
   localparam logic [MODE_BITS-1:0] MODE_PEAK = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RMS  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOG  = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ATTACK  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RELEASE = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW  = 2'd3;

   // Register reset values
   localparam logic [COEF_BITS-1:0] RELEASE_RESET = 16'd65000;
   localparam logic [WLEN_BITS-1:0] WINDOW_RESET  = 11'd64;

   // 10*log10(2) in Q2.24, and the floor for a zero mean
   localparam logic [25:0] DB_K = 26'd50504453;
   localparam logic signed [ENV_BITS-1:0] DB_FLOOR = -25'sd61440;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PEAK_MUL,
      ST_SQ_MUL,
      ST_OSQ_MUL,
      ST_SUM,
      ST_DIV,
      ST_SQRT,
      ST_SQRT_RND,
      ST_NORM,
      ST_LOG_MUL,
      ST_DB_MUL,
      ST_OUT
   } state_type;

endpackage

### hdl/streaming_envelope_detector_unit.sv
// Top level of the streaming envelope detector: control, datapath and sample history.
//
// Usage: one signed sample enters on the req_ channel (req_valid/req_stall), and one
// envelope value leaves on the rsp_ channel (rsp_valid/rsp_stall) for each sample.
// req_restart marks the first sample of a batch and clears envelope, sum and count.
// Registers are written on the csr_ port (csr_we, csr_addr, csr_wdata): mode, attack
// coefficient, release coefficient and window length. The user must write them only
// while idle; the block itself does not enforce this. The block works on one sample
// at a time: each sample takes up to three products of the 4-bit-digit multiplier,
// the third only once the window is full; then peak mode answers. RMS adds the
// bit-serial divider and the bit-serial square root; log mode adds the divider,
// normalization shifts and 17 products.
// The next sample is taken once the result is in the output register.
// Reset clears the registers to their defaults and empties envelope, sum, count and
// window position; the sample history needs no clearing.
// A stalled result is held in the output register; the next result waits behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module streaming_envelope_detector_unit #(
   parameter int WINDOW_MAX = sedu_pkg::WINDOW_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [sedu_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic req_restart,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [sedu_pkg::ENV_BITS-1:0] rsp_envelope,
   input  logic csr_we,
   input  logic [sedu_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [sedu_pkg::COEF_BITS-1:0] csr_wdata
);

   localparam int SB  = sedu_pkg::SAMPLE_BITS;
   localparam int PB  = sedu_pkg::PEAK_BITS;
   localparam int SMB = sedu_pkg::SUM_BITS;
   localparam int MB  = sedu_pkg::MEAN_BITS;
   localparam int LB  = sedu_pkg::WLEN_BITS;
   localparam int EB  = sedu_pkg::ENV_BITS;
   localparam int CFB = sedu_pkg::COEF_BITS;
   localparam int MW  = sedu_pkg::MUL_BITS;
   localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SW  = AW + 1;
   localparam int WIN_CAP = (WINDOW_MAX > 2047) ? 2047 : WINDOW_MAX;

   sedu_pkg::state_type state_ff, state_in;

   // configuration
   logic [sedu_pkg::MODE_BITS-1:0] mode_ff;
   logic [CFB-1:0] attack_ff, release_ff;
   logic [LB-1:0]  wlen_ff;

   // model state
   logic [PB-1:0]  peak_ff, peak_in;
   logic [SMB-1:0] sum_ff, sum_in;
   logic [LB-1:0]  seen_ff, seen_in;
   logic [AW-1:0]  ws_ff, ws_in;

   // per-sample work registers
   logic [SB-1:0]  x_ff, x_in;
   logic [PB-1:0]  a8_ff, a8_in;
   logic [PB-1:0]  dmag_ff, dmag_in;
   logic           dneg_ff, dneg_in;
   logic [CFB-1:0] coef_ff, coef_in;
   logic [LB-1:0]  len_ff, len_in;
   logic           drop_ff, drop_in;
   logic [30:0]    sq_ff, sq_in;
   logic [MB-1:0]  dvd_ff, dvd_in;
   logic [LB-1:0]  rem_ff, rem_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [MB-1:0]  sx_ff, sx_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [5:0]     n_ff, n_in;
   logic [30:0]    lx_ff, lx_in;
   logic [15:0]    frac_ff, frac_in;
   logic [21:0]    lmag_ff, lmag_in;
   logic           lneg_ff, lneg_in;
   logic [EB-1:0]  res_ff, res_in;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [EB-1:0]  rsp_env_ff, rsp_env_in;

   // multiplier and memory hookup
   logic              mul_go, mul_busy, mul_done;
   logic [MW-1:0]     mul_a, mul_b;
   logic [2*MW-1:0]   mul_p;
   logic              ram_rd_en, ram_wr_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [SB-1:0]     ram_rd_data;

   // combinational helpers
   logic           accept;
   logic [SB-1:0]  ax, ao;
   logic [PB-1:0]  a8, peak_eff;
   logic [LB-1:0]  len_eff, seen_eff, seen_c;
   logic [SW-1:0]  slot_t;
   logic [SMB-1:0] base, total, osq, s1;
   logic [LB:0]    dtrial;
   logic [MB-1:0]  strial;
   logic [31:0]    ysq;
   logic [22:0]    lfull;
   logic [48:0]    qsum;
   logic [16:0]    q;

   assign accept    = req_valid && (state_ff == sedu_pkg::ST_IDLE);
   assign req_stall = (state_ff != sedu_pkg::ST_IDLE);

   sedu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .done  (mul_done),
      .p     (mul_p)
   );

   sedu_ram #(
      .WIDTH (SB),
      .DEPTH (WINDOW_MAX)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ws_ff),
      .wr_data (x_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // rectify, clamp window length, locate the sample that leaves the window
   always_comb begin
      ax       = req_sample[SB-1] ? SB'(~req_sample + 1'b1) : req_sample;
      ao       = ram_rd_data[SB-1] ? SB'(~ram_rd_data + 1'b1) : ram_rd_data;
      a8       = {ax, 8'h00};
      peak_eff = req_restart ? '0 : peak_ff;
      seen_eff = req_restart ? '0 : seen_ff;
      if (wlen_ff == '0) begin
         len_eff = LB'(1);
      end else if (wlen_ff > LB'(WIN_CAP)) begin
         len_eff = LB'(WIN_CAP);
      end else begin
         len_eff = wlen_ff;
      end
      seen_c = (seen_eff > len_eff) ? len_eff : seen_eff;
      slot_t = SW'(ws_ff) + SW'(WINDOW_MAX) - SW'(len_eff);
      if (slot_t >= SW'(WINDOW_MAX)) begin
         slot_t = slot_t - SW'(WINDOW_MAX);
      end
      ram_rd_addr = slot_t[AW-1:0];
      ram_rd_en   = accept;
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         sedu_pkg::ST_PEAK_MUL: begin
            mul_a = MW'(dmag_ff);
            mul_b = MW'(coef_ff);
         end
         sedu_pkg::ST_SQ_MUL: begin
            mul_a = MW'(x_ff[SB-1] ? SB'(~x_ff + 1'b1) : x_ff);
            mul_b = mul_a;
         end
         sedu_pkg::ST_OSQ_MUL: begin
            mul_a = MW'(ao);
            mul_b = MW'(ao);
         end
         sedu_pkg::ST_LOG_MUL: begin
            mul_a = MW'(lx_ff);
            mul_b = MW'(lx_ff);
         end
         sedu_pkg::ST_DB_MUL: begin
            mul_a = MW'(lmag_ff);
            mul_b = MW'(sedu_pkg::DB_K);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_go = ((state_ff == sedu_pkg::ST_PEAK_MUL) || (state_ff == sedu_pkg::ST_SQ_MUL) ||
                (state_ff == sedu_pkg::ST_OSQ_MUL) || (state_ff == sedu_pkg::ST_LOG_MUL) ||
                (state_ff == sedu_pkg::ST_DB_MUL)) && !mul_busy && !mul_done;
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      peak_in  = peak_ff;
      sum_in   = sum_ff;
      seen_in  = seen_ff;
      ws_in    = ws_ff;
      x_in     = x_ff;
      a8_in    = a8_ff;
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      coef_in  = coef_ff;
      len_in   = len_ff;
      drop_in  = drop_ff;
      sq_in    = sq_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      sx_in    = sx_ff;
      sr_in    = sr_ff;
      sb_in    = sb_ff;
      n_in     = n_ff;
      lx_in    = lx_ff;
      frac_in  = frac_ff;
      lmag_in  = lmag_ff;
      lneg_in  = lneg_ff;
      res_in   = res_ff;
      ram_wr_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_env_in   = rsp_env_ff;

      base   = {1'b0, a8_ff, 16'h8000};
      total  = dneg_ff ? base - SMB'(mul_p[39:0]) : base + SMB'(mul_p[39:0]);
      osq    = SMB'(mul_p[30:0]);
      s1     = drop_ff ? ((sum_ff >= osq) ? sum_ff - osq : '0) : sum_ff;
      dtrial = {rem_ff, dvd_ff[MB-1]} - {1'b0, seen_ff};
      strial = sr_ff + sb_ff;
      ysq    = mul_p[61:30];
      lfull  = 23'({n_ff, frac_ff}) - 23'(1 << 20);
      qsum   = 49'(mul_p[47:0]) + 49'(64'd1 << 31);
      q      = qsum[48:32];

      case (state_ff)
         sedu_pkg::ST_IDLE: begin
            // take a sample, apply restart, set up the follower product
            if (accept) begin
               x_in  = req_sample;
               a8_in = a8;
               if (req_restart) begin
                  peak_in = '0;
                  sum_in  = '0;
               end
               dneg_in = (a8 > peak_eff);
               coef_in = (a8 > peak_eff) ? attack_ff : release_ff;
               dmag_in = (a8 > peak_eff) ? a8 - peak_eff : peak_eff - a8;
               len_in  = len_eff;
               seen_in = seen_c;
               drop_in = (seen_c == len_eff);
               state_in = sedu_pkg::ST_PEAK_MUL;
            end
         end
         sedu_pkg::ST_PEAK_MUL: begin
            if (mul_done) begin
               peak_in  = total[PB+15:16];
               state_in = sedu_pkg::ST_SQ_MUL;
            end
         end
         sedu_pkg::ST_SQ_MUL: begin
            if (mul_done) begin
               sq_in    = mul_p[30:0];
               state_in = drop_ff ? sedu_pkg::ST_OSQ_MUL : sedu_pkg::ST_SUM;
            end
         end
         sedu_pkg::ST_OSQ_MUL: begin
            if (mul_done) begin
               state_in = sedu_pkg::ST_SUM;
            end
         end
         sedu_pkg::ST_SUM: begin
            // drop the oldest square if the window is full, add the new one, store the sample
            sum_in    = s1 + SMB'(sq_ff);
            ram_wr_en = 1'b1;
            ws_in     = (ws_ff == AW'(WINDOW_MAX - 1)) ? '0 : ws_ff + 1'b1;
            if (seen_ff < len_ff) begin
               seen_in = seen_ff + 1'b1;
            end
            dvd_in = {sum_in, 16'h0000};
            rem_in = '0;
            cnt_in = '0;
            if (mode_ff == sedu_pkg::MODE_PEAK) begin
               res_in   = EB'(peak_ff);
               state_in = sedu_pkg::ST_OUT;
            end else begin
               state_in = sedu_pkg::ST_DIV;
            end
         end
         sedu_pkg::ST_DIV: begin
            // one quotient bit per cycle
            if (!dtrial[LB]) begin
               rem_in = dtrial[LB-1:0];
               dvd_in = {dvd_ff[MB-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[LB-2:0], dvd_ff[MB-1]};
               dvd_in = {dvd_ff[MB-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(MB - 1)) begin
               if (mode_ff == sedu_pkg::MODE_LOG) begin
                  if (dvd_in == '0) begin
                     res_in   = sedu_pkg::DB_FLOOR;
                     state_in = sedu_pkg::ST_OUT;
                  end else begin
                     sx_in    = dvd_in;
                     n_in     = 6'(MB - 1);
                     state_in = sedu_pkg::ST_NORM;
                  end
               end else begin
                  sx_in    = dvd_in;
                  sr_in    = '0;
                  sb_in    = MB'(1) << (MB - 1);
                  state_in = sedu_pkg::ST_SQRT;
               end
            end
         end
         sedu_pkg::ST_SQRT: begin
            // one root bit per cycle
            if (sx_ff >= strial) begin
               sx_in = sx_ff - strial;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            if (sb_ff == MB'(1)) begin
               state_in = sedu_pkg::ST_SQRT_RND;
            end
         end
         sedu_pkg::ST_SQRT_RND: begin
            // round to nearest, ties up
            res_in   = (sx_ff > sr_ff) ? EB'(sr_ff + 1'b1) : EB'(sr_ff);
            state_in = sedu_pkg::ST_OUT;
         end
         sedu_pkg::ST_NORM: begin
            // shift until the leading one reaches the top
            if (sx_ff[MB-1]) begin
               lx_in    = sx_ff[MB-1:MB-31];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = sedu_pkg::ST_LOG_MUL;
            end else begin
               sx_in = sx_ff << 1;
               n_in  = n_ff - 1'b1;
            end
         end
         sedu_pkg::ST_LOG_MUL: begin
            // square, keep one fraction bit per square
            if (mul_done) begin
               if (ysq[31]) begin
                  lx_in   = ysq[31:1];
                  frac_in = {frac_ff[14:0], 1'b1};
               end else begin
                  lx_in   = ysq[30:0];
                  frac_in = {frac_ff[14:0], 1'b0};
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 6'd15) begin
                  state_in = sedu_pkg::ST_DB_MUL;
               end
            end
            if (state_ff == sedu_pkg::ST_LOG_MUL && cnt_ff == 6'd16) begin
               cnt_in = cnt_ff;
            end
         end
         sedu_pkg::ST_DB_MUL: begin
            // scale log2 to dB, round half away from zero
            if (!mul_busy && !mul_done && lmag_ff == lmag_in) begin
               lneg_in = lneg_ff;
            end
            if (mul_done) begin
               res_in   = lneg_ff ? EB'(-EB'(q)) : EB'(q);
               state_in = sedu_pkg::ST_OUT;
            end
         end
         sedu_pkg::ST_OUT: begin
            // hand the result to the output register when it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_env_in   = res_ff;
               state_in     = sedu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sedu_pkg::ST_IDLE;
         end
      endcase

      // form the signed log2 value as the last square completes
      if (state_ff == sedu_pkg::ST_LOG_MUL && mul_done && cnt_ff == 6'd15) begin
         lfull   = 23'({n_ff, frac_in}) - 23'(1 << 20);
         lneg_in = lfull[22];
         lmag_in = lfull[22] ? 22'(-lfull) : lfull[21:0];
      end
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sedu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= sedu_pkg::MODE_PEAK;
         attack_ff    <= '0;
         release_ff   <= sedu_pkg::RELEASE_RESET;
         wlen_ff      <= sedu_pkg::WINDOW_RESET;
         peak_ff      <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         ws_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         ws_ff        <= ws_in;
         if (csr_we) begin
            case (csr_addr)
               sedu_pkg::CSR_MODE:    mode_ff    <= csr_wdata[sedu_pkg::MODE_BITS-1:0];
               sedu_pkg::CSR_ATTACK:  attack_ff  <= csr_wdata;
               sedu_pkg::CSR_RELEASE: release_ff <= csr_wdata;
               sedu_pkg::CSR_WINDOW:  wlen_ff    <= csr_wdata[LB-1:0];
               default: begin
                  mode_ff <= mode_ff;
               end
            endcase
         end
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      a8_ff      <= a8_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      coef_ff    <= coef_in;
      len_ff     <= len_in;
      drop_ff    <= drop_in;
      sq_ff      <= sq_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      sx_ff      <= sx_in;
      sr_ff      <= sr_in;
      sb_ff      <= sb_in;
      n_ff       <= n_in;
      lx_ff      <= lx_in;
      frac_ff    <= frac_in;
      lmag_ff    <= lmag_in;
      lneg_ff    <= lneg_in;
      res_ff     <= res_in;
      rsp_env_ff <= rsp_env_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_envelope = $signed(rsp_env_ff);

   `SEDU_ASSERT(a_div_nonzero, clock, reset, (state_ff != sedu_pkg::ST_DIV) || ((seen_ff != '0) && (seen_ff <= len_ff)), "divisor out of range")
   `SEDU_ASSERT_NEXT(a_one_at_a_time, clock, reset, accept, req_stall, "second sample taken while busy")
   `SEDU_ASSERT(a_log_norm, clock, reset, (state_ff != sedu_pkg::ST_LOG_MUL) || lx_ff[30], "log operand not normalized")

endmodule

### hdl/sedu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sedu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sedu_mul.sv
// Digit-serial unsigned multiplier, four bits of the second operand per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sedu_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [sedu_pkg::MUL_BITS-1:0] a,
   input  logic [sedu_pkg::MUL_BITS-1:0] b,
   output logic                         busy,
   output logic                         done,
   output logic [2*sedu_pkg::MUL_BITS-1:0] p
);

   localparam int W  = sedu_pkg::MUL_BITS;
   localparam int D  = sedu_pkg::MUL_DIGIT;
   localparam int NS = W / D;
   localparam int CB = $clog2(NS);

   logic [W-1:0]   a_ff, a_in;
   logic [W-1:0]   b_ff, b_in;
   logic [2*W-1:0] p_ff, p_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [W+D-1:0] part;

   // one digit step: add a*digit to the upper half, shift the product right
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      part    = (W+D)'(p_ff[2*W-1:W]) + (W+D)'(a_ff) * (W+D)'(b_ff[D-1:0]);
      if (go && !busy_ff) begin
         a_in    = a;
         b_in    = b;
         p_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {part, p_ff[W-1:D]};
         b_in   = b_ff >> D;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CB'(NS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand and product registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign p    = p_ff;

   `SEDU_ASSERT_NEXT(a_mul_done_once, clock, reset, done_ff, !done_ff, "done held two cycles")
   `SEDU_ASSERT(a_mul_busy_done, clock, reset, !(busy_ff && done_ff), "busy and done together")
   `SEDU_ASSERT_NEXT(a_mul_start, clock, reset, go && !busy_ff, busy_ff, "go did not start")

endmodule

### dv/streaming_envelope_detector_unit_test.sv
// Self-checking testbench for the streaming envelope detector with its own envelope predictor.
`timescale 1ns / 1ps

module streaming_envelope_detector_unit_test;

   localparam int HIST_DEPTH = 1024;
   localparam int QUIET_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 400;
   localparam int BATCH_ITEMS = 73;

   typedef struct {
      logic signed [sedu_pkg::SAMPLE_BITS-1:0] sample;
      logic restart;
   } sample_item_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [sedu_pkg::SAMPLE_BITS-1:0] req_sample;
   logic req_restart;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [sedu_pkg::ENV_BITS-1:0] rsp_envelope;
   logic csr_we;
   logic [sedu_pkg::CSR_ADDR_BITS-1:0] csr_addr;
   logic [sedu_pkg::COEF_BITS-1:0] csr_wdata;

   streaming_envelope_detector_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_envelope(rsp_envelope),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Predictor copy of the registers and state
   logic [1:0] cfg_mode;
   logic [63:0] cfg_attack, cfg_release, cfg_window;
   logic [63:0] peak_track, sum_track, slot_track, count_track;
   longint history_track [HIST_DEPTH];

   sample_item_type pending_samples [$];
   logic [sedu_pkg::ENV_BITS-1:0] expected_envelopes [$];
   int fail_count = 0;
   int quiet_cycles = 0;
   bit transfer_taken = 0;
   bit sender_idles = 1;
   bit receiver_idles = 1;
   int hold_request = 0;

   function automatic logic [63:0] root_rounded(logic [63:0] m);
      logic [63:0] r, bitv, x;
      r = 0;
      bitv = 64'd1 << 62;
      x = m;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      if (m - r * r > r) r = r + 1;
      return r;
   endfunction

   function automatic logic [63:0] mean_to_db(logic [63:0] m);
      int n;
      logic [63:0] x, frac, up;
      longint lg, p;
      if (m == 0) return 64'(longint'(sedu_pkg::DB_FLOOR));
      n = 0;
      frac = 0;
      while ((m >> n) > 1) n++;
      x = (n >= 30) ? (m >> (n - 30)) : (m << (30 - n));
      // iterate squarings to pull out fraction bits of log2
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= 64'h8000_0000) begin
            x = x >> 1;
            frac = frac | 1;
         end
      end
      lg = longint'((64'(n) << 16) | frac) - longint'(16 << 16);
      if (lg < 0) begin
         p = -lg * longint'(sedu_pkg::DB_K);
         up = (64'(p) + 64'h8000_0000) >> 32;
         return -up;
      end
      p = lg * longint'(sedu_pkg::DB_K);
      return (64'(p) + 64'h8000_0000) >> 32;
   endfunction

   // Advance predictor state by one sample and return the answer
   function automatic logic [sedu_pkg::ENV_BITS-1:0] follow_envelope(
         logic signed [sedu_pkg::SAMPLE_BITS-1:0] s, logic rst);
      longint xs, old;
      logic [63:0] ax, a8, len, c, osq, mean, res, slot;
      xs = s;
      ax = (xs < 0) ? 64'(-xs) : 64'(xs);
      a8 = ax << 8;
      if (rst) begin
         peak_track = 0;
         sum_track = 0;
         count_track = 0;
      end
      len = cfg_window;
      if (len == 0) len = 1;
      if (len > HIST_DEPTH) len = HIST_DEPTH;
      c = (a8 > peak_track) ? cfg_attack : cfg_release;
      peak_track = (c * peak_track + (65536 - c) * a8 + 32768) >> 16;
      if (count_track > len) count_track = len;
      // drop the oldest square once the window is full
      if (count_track == len) begin
         slot = (slot_track + HIST_DEPTH - len) % HIST_DEPTH;
         old = history_track[slot];
         osq = (old < 0) ? 64'(-old) : 64'(old);
         osq = osq * osq;
         sum_track = (sum_track >= osq) ? sum_track - osq : 0;
      end
      sum_track = sum_track + ax * ax;
      history_track[slot_track % HIST_DEPTH] = xs;
      slot_track = (slot_track + 1) % HIST_DEPTH;
      if (count_track < len) count_track++;
      mean = (sum_track << 16) / count_track;
      if (cfg_mode == sedu_pkg::MODE_PEAK) res = peak_track;
      else if (cfg_mode == sedu_pkg::MODE_LOG) res = mean_to_db(mean);
      else res = root_rounded(mean);
      return res[sedu_pkg::ENV_BITS-1:0];
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Detect input transfers and record the expected envelope
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_envelopes.push_back(follow_envelope(req_sample, req_restart));
         transfer_taken = 1;
         quiet_cycles = 0;
      end
   end

   // Driver: feed pending samples, with random gaps while sender_idles is set
   int gap_left = 0;
   always @(negedge clock) begin
      bit valid_next;
      sample_item_type it;
      valid_next = req_valid;
      if (transfer_taken) begin
         transfer_taken = 0;
         valid_next = 0;
         gap_left = sender_idles ? $urandom_range(0, 17) : 0;
      end
      if (!valid_next && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_samples.size() > 0) begin
            it = pending_samples.pop_front();
            req_sample <= it.sample;
            req_restart <= it.restart;
            valid_next = 1;
         end
      end
      req_valid <= valid_next;
   end

   // Monitor: stall the result channel and check each result transfer
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      logic [sedu_pkg::ENV_BITS-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         quiet_cycles = 0;
         if (expected_envelopes.size() == 0) begin
            $error("unexpected result: envelope actual %0d", rsp_envelope);
            fail_count++;
         end else begin
            want = expected_envelopes.pop_front();
            if (rsp_envelope !== want) begin
               $error("envelope mismatch: expected %0d actual %0d",
                      $signed(want), rsp_envelope);
               fail_count++;
            end
         end
         stall_left = receiver_idles ? $urandom_range(0, 17) : 0;
      end
   end

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // Watchdog on cycles without any transfer
   always @(negedge clock) begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("streaming_envelope_detector_unit_test failed");
         $finish;
      end
   end

   task automatic write_reg(logic [sedu_pkg::CSR_ADDR_BITS-1:0] idx,
                            logic [sedu_pkg::COEF_BITS-1:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         sedu_pkg::CSR_MODE:    cfg_mode = val[1:0];
         sedu_pkg::CSR_ATTACK:  cfg_attack = val;
         sedu_pkg::CSR_RELEASE: cfg_release = val;
         sedu_pkg::CSR_WINDOW:  cfg_window = val[sedu_pkg::WLEN_BITS-1:0];
         default: begin
            cfg_mode = cfg_mode;
         end
      endcase
      @(negedge clock);
      csr_we <= 0;
      quiet_cycles = 0;
   endtask

   task automatic configure(logic [1:0] m, logic [15:0] a, logic [15:0] r, logic [15:0] w);
      write_reg(sedu_pkg::CSR_MODE, 16'(m));
      write_reg(sedu_pkg::CSR_ATTACK, a);
      write_reg(sedu_pkg::CSR_RELEASE, r);
      write_reg(sedu_pkg::CSR_WINDOW, w);
   endtask

   task automatic push_sample(int s, bit rst);
      sample_item_type it;
      it.sample = s[sedu_pkg::SAMPLE_BITS-1:0];
      it.restart = rst;
      pending_samples.push_back(it);
   endtask

   // Wait for all results, then let the block settle before touching registers
   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_envelopes.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic int random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return int'($signed(16'($urandom)));
      if (pick < 50) return $urandom_range(0, 128) - 64;
      if (pick < 60) return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      return $urandom_range(0, 8192) - 4096;
   endfunction

   function automatic logic [15:0] random_coeff();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'd0;
      if (pick == 1) return 16'hFFFF;
      if (pick < 5) return 16'($urandom_range(60000, 65535));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] random_window();
      int pick;
      pick = $urandom_range(0, 11);
      case (pick)
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd1024;
         3: return 16'd1025;
         4: return 16'd2047;
         5: return 16'($urandom_range(1025, 2047));
         6: return 16'($urandom_range(65, 1024));
         default: return 16'($urandom_range(1, 64));
      endcase
   endfunction

   initial begin
      reset = 1;
      req_valid = 0;
      req_sample = 0;
      req_restart = 0;
      rsp_stall = 0;
      csr_we = 0;
      csr_addr = sedu_pkg::CSR_MODE;
      csr_wdata = 0;
      cfg_mode = sedu_pkg::MODE_PEAK;
      cfg_attack = 0;
      cfg_release = 65000;
      cfg_window = 64;
      peak_track = 0;
      sum_track = 0;
      slot_track = 0;
      count_track = 0;
      foreach (history_track[i]) history_track[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: a few samples at reset defaults, then extremes per mode
      push_sample(32767, 1);
      push_sample(-32768, 0);
      push_sample(0, 0);
      drain();
      configure(sedu_pkg::MODE_PEAK, 16'd0, 16'hFFFF, 16'd1);
      push_sample(-32768, 1);
      push_sample(32767, 0);
      push_sample(-1, 0);
      push_sample(1, 0);
      push_sample(0, 0);
      drain();
      configure(sedu_pkg::MODE_RMS, 16'hFFFF, 16'd0, 16'd4);
      push_sample(-32768, 1);
      push_sample(-32768, 0);
      push_sample(32767, 0);
      push_sample(1, 0);
      push_sample(0, 0);
      push_sample(0, 0);
      push_sample(0, 0);
      drain();
      configure(sedu_pkg::MODE_LOG, 16'd1000, 16'd65000, 16'd0);
      push_sample(0, 1);
      push_sample(1, 0);
      push_sample(-32768, 0);
      push_sample(-1, 1);
      drain();
      configure(2'd3, 16'd1000, 16'd65000, 16'd2047);
      push_sample(32767, 1);
      push_sample(-300, 0);
      push_sample(5, 0);
      // window shrinks inside a batch
      drain();
      write_reg(sedu_pkg::CSR_WINDOW, 16'd2);
      push_sample(7, 0);
      push_sample(-9, 0);
      drain();

      // random phases, one with a long receiver hold-off
      for (int ph = 0; ph < 24; ph++) begin
         configure(2'($urandom_range(0, 3)), random_coeff(), random_coeff(), random_window());
         sender_idles = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         if (ph == 3) hold_request = 2500;
         for (int k = 0; k < BATCH_ITEMS; k++)
            push_sample(random_sample(), (k == 0) || ($urandom_range(0, 49) == 0));
         // sometimes change the window within the batch
         if (ph % 4 == 1) begin
            drain();
            write_reg(sedu_pkg::CSR_WINDOW, random_window());
            for (int k = 0; k < 20; k++) push_sample(random_sample(), 0);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("streaming_envelope_detector_unit_test passed");
      end else begin
         $display("streaming_envelope_detector_unit_test failed");
      end
      $finish;
   end

endmodule
